// ===== sv/touch_contact_slot_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Touch contact slot tracker assertion macros
// Concurrent assertion shorthands shared by the tracker modules.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_SLOT_TRACKER_UNIT_ASSERT_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TCST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

`define TCST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`define TCST_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tracker assertion failed");

`else

`define TCST_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TCST_ASSERT_NEXT(label, clk, rst, ante, cons)
`define TCST_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

// ===== sv/tcst_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch contact slot tracker package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tcst_pkg;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int COORD_W   = 16;
  localparam int ID_W      = 8;
  localparam int OWNER_W   = ID_W + 1;
  localparam int DIM_W     = 15;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [OWNER_W-1:0] OWNER_NONE = '1;
  localparam logic [COORD_W-1:0] COORD_NONE = '1;
  localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(480);
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(320);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACT_DOWN       = 3'd0,
    ACT_UP         = 3'd1,
    ACT_MOVE       = 3'd2,
    ACT_FRAME      = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_SLOT_WRITE = 3'd5,
    ACT_QUERY      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_DOWN = 2'd1,
    ST_UP   = 2'd2,
    ST_MOVE = 2'd3
  } slot_status_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

// ===== sv/tcst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch contact slot tracker controller
// Sequences load, slot scan and result publish for one word at a time.
// ----------------------------------------------------------------------------
`include "touch_contact_slot_tracker_unit_assert.svh"

module tcst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tcst_pkg::dp_status_t status,
  output tcst_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign accept   = (state == S_IDLE) && in_valid;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load    = in_valid;
      S_SCAN: cmd.step    = 1'b1;
      S_DONE: cmd.publish = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TCST_ASSERT_NEXT(a_accept_starts_scan, clk, rst, accept, state == S_SCAN)
  `TCST_ASSERT_NEXT(a_blocked_result_holds, clk, rst,
                    (state == S_DONE) && out_valid && out_stall, state == S_DONE)
  `TCST_ASSERT_NEXT(a_publish_shows_word, clk, rst,
                    (state == S_DONE) && out_free, out_valid && (state == S_IDLE))

endmodule

// ===== sv/tcst_datapath.sv =====
// ----------------------------------------------------------------------------
// Touch contact slot tracker datapath
// Slot table, item registers, per-slot update logic and result register.
// ----------------------------------------------------------------------------
`include "touch_contact_slot_tracker_unit_assert.svh"

module tcst_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tcst_pkg::dp_cmd_t                    cmd,
  output tcst_pkg::dp_status_t                 status,
  input  logic                                 cfg_we,
  input  logic [tcst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcst_pkg::DIM_W-1:0]           cfg_data,
  input  logic [2:0]                           action,
  input  logic signed [tcst_pkg::COORD_W-1:0]  x_pos,
  input  logic signed [tcst_pkg::COORD_W-1:0]  y_pos,
  input  logic [tcst_pkg::ID_W-1:0]            contact_id,
  input  logic [tcst_pkg::IDX_W-1:0]           slot_index,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_left,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_top,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_right,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_bottom,
  output logic                                 slot_hit,
  output logic                                 any_down,
  output logic                                 any_up,
  output logic                                 down_in_rect,
  output logic                                 up_in_rect,
  output logic                                 point_in_rect,
  output logic signed [tcst_pkg::COORD_W-1:0]  read_x,
  output logic signed [tcst_pkg::COORD_W-1:0]  read_y,
  output logic signed [tcst_pkg::OWNER_W-1:0]  read_id,
  output logic [1:0]                           read_status
);

  logic [tcst_pkg::DIM_W-1:0] scr_w;
  logic [tcst_pkg::DIM_W-1:0] scr_h;

  logic signed [tcst_pkg::COORD_W-1:0] slot_x [tcst_pkg::NUM_SLOTS];
  logic signed [tcst_pkg::COORD_W-1:0] slot_y [tcst_pkg::NUM_SLOTS];
  logic [tcst_pkg::OWNER_W-1:0]        slot_owner [tcst_pkg::NUM_SLOTS];
  tcst_pkg::slot_status_t              slot_stat [tcst_pkg::NUM_SLOTS];

  logic [tcst_pkg::SLOT_W-1:0] cnt;

  tcst_pkg::action_t                   act;
  logic signed [tcst_pkg::COORD_W-1:0] px;
  logic signed [tcst_pkg::COORD_W-1:0] py;
  logic [tcst_pkg::ID_W-1:0]           pid;
  logic [tcst_pkg::IDX_W-1:0]          pidx;
  logic signed [tcst_pkg::COORD_W-1:0] rl;
  logic signed [tcst_pkg::COORD_W-1:0] rt;
  logic signed [tcst_pkg::COORD_W-1:0] rr;
  logic signed [tcst_pkg::COORD_W-1:0] rb;

  logic                                found;
  logic                                acc_down;
  logic                                acc_up;
  logic                                acc_din;
  logic                                acc_uin;
  logic                                acc_pin;
  logic signed [tcst_pkg::COORD_W-1:0] acc_rx;
  logic signed [tcst_pkg::COORD_W-1:0] acc_ry;
  logic [tcst_pkg::OWNER_W-1:0]        acc_rid;
  logic [1:0]                          acc_rst;

  logic signed [tcst_pkg::COORD_W-1:0] cur_x;
  logic signed [tcst_pkg::COORD_W-1:0] cur_y;
  logic [tcst_pkg::OWNER_W-1:0]        cur_o;
  tcst_pkg::slot_status_t              cur_s;
  logic signed [tcst_pkg::COORD_W-1:0] nx;
  logic signed [tcst_pkg::COORD_W-1:0] ny;
  logic [tcst_pkg::OWNER_W-1:0]        no;
  tcst_pkg::slot_status_t              ns;
  logic                                take;
  logic                                idx_hit;
  logic                                at_border;
  logic                                in_box;
  logic signed [tcst_pkg::COORD_W-1:0] scr_w_s;
  logic signed [tcst_pkg::COORD_W-1:0] scr_h_s;

  assign status.scan_last = (cnt == tcst_pkg::SLOT_W'(tcst_pkg::NUM_SLOTS - 1));

  assign cur_x = slot_x[cnt];
  assign cur_y = slot_y[cnt];
  assign cur_o = slot_owner[cnt];
  assign cur_s = slot_stat[cnt];

  assign scr_w_s = $signed({1'b0, scr_w});
  assign scr_h_s = $signed({1'b0, scr_h});

  assign idx_hit   = (32'(pidx) == 32'(cnt));
  assign at_border = (px <= 0) || (py <= 0) || (px >= scr_w_s) || (py >= scr_h_s);
  assign in_box    = (cur_x >= rl) && (cur_x < rr) && (cur_y >= rt) && (cur_y < rb);

  always_comb begin
    nx   = cur_x;
    ny   = cur_y;
    no   = cur_o;
    ns   = cur_s;
    take = 1'b0;
    case (act)
      tcst_pkg::ACT_DOWN: begin
        if (!found && (cur_s == tcst_pkg::ST_NONE)) begin
          nx   = px;
          ny   = py;
          no   = {1'b0, pid};
          ns   = tcst_pkg::ST_DOWN;
          take = 1'b1;
        end
      end
      tcst_pkg::ACT_UP, tcst_pkg::ACT_MOVE: begin
        if (!found && (cur_o == {1'b0, pid})) begin
          nx   = px;
          ny   = py;
          ns   = ((act == tcst_pkg::ACT_UP) || at_border) ? tcst_pkg::ST_UP
                                                          : tcst_pkg::ST_MOVE;
          take = 1'b1;
        end
      end
      tcst_pkg::ACT_FRAME: begin
        if (cur_s == tcst_pkg::ST_UP) begin
          nx = tcst_pkg::COORD_NONE;
          ny = tcst_pkg::COORD_NONE;
          ns = tcst_pkg::ST_NONE;
        end
      end
      tcst_pkg::ACT_CLEAR: begin
        nx = tcst_pkg::COORD_NONE;
        ny = tcst_pkg::COORD_NONE;
        no = tcst_pkg::OWNER_NONE;
        ns = tcst_pkg::ST_NONE;
      end
      tcst_pkg::ACT_SLOT_WRITE: begin
        if (idx_hit) begin
          nx = px;
          ny = py;
          if (px[tcst_pkg::COORD_W-1] || py[tcst_pkg::COORD_W-1]) begin
            no = tcst_pkg::OWNER_NONE;
            ns = tcst_pkg::ST_NONE;
          end else begin
            no = {1'b0, pid};
            ns = (cur_s == tcst_pkg::ST_NONE) ? tcst_pkg::ST_DOWN : tcst_pkg::ST_MOVE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= tcst_pkg::WIDTH_RESET;
      scr_h <= tcst_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (tcst_pkg::cfg_reg_t'(cfg_index))
        tcst_pkg::CFG_SCREEN_WIDTH:  scr_w <= cfg_data;
        tcst_pkg::CFG_SCREEN_HEIGHT: scr_h <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tcst_pkg::NUM_SLOTS; i++) begin
        slot_x[i]     <= tcst_pkg::COORD_NONE;
        slot_y[i]     <= tcst_pkg::COORD_NONE;
        slot_owner[i] <= tcst_pkg::OWNER_NONE;
        slot_stat[i]  <= tcst_pkg::ST_NONE;
      end
    end else if (cmd.step) begin
      slot_x[cnt]     <= nx;
      slot_y[cnt]     <= ny;
      slot_owner[cnt] <= no;
      slot_stat[cnt]  <= ns;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step && !status.scan_last) begin
      cnt <= cnt + tcst_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act      <= tcst_pkg::action_t'(action);
      px       <= x_pos;
      py       <= y_pos;
      pid      <= contact_id;
      pidx     <= slot_index;
      rl       <= rect_left;
      rt       <= rect_top;
      rr       <= rect_right;
      rb       <= rect_bottom;
      found    <= 1'b0;
      acc_down <= 1'b0;
      acc_up   <= 1'b0;
      acc_din  <= 1'b0;
      acc_uin  <= 1'b0;
      acc_pin  <= 1'b0;
      acc_rx   <= '0;
      acc_ry   <= '0;
      acc_rid  <= '0;
      acc_rst  <= '0;
    end else if (cmd.step) begin
      found <= found | take;
      if (ns == tcst_pkg::ST_DOWN) begin
        acc_down <= 1'b1;
      end
      if (ns == tcst_pkg::ST_UP) begin
        acc_up <= 1'b1;
      end
      if (act == tcst_pkg::ACT_QUERY) begin
        if (in_box) begin
          acc_pin <= 1'b1;
          if (cur_s == tcst_pkg::ST_DOWN) begin
            acc_din <= 1'b1;
          end
          if (cur_s == tcst_pkg::ST_UP) begin
            acc_uin <= 1'b1;
          end
        end
        if (idx_hit) begin
          acc_rx  <= cur_x;
          acc_ry  <= cur_y;
          acc_rid <= cur_o;
          acc_rst <= cur_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      slot_hit      <= found;
      any_down      <= acc_down;
      any_up        <= acc_up;
      down_in_rect  <= acc_din;
      up_in_rect    <= acc_uin;
      point_in_rect <= acc_pin;
      read_x        <= acc_rx;
      read_y        <= acc_ry;
      read_id       <= $signed(acc_rid);
      read_status   <= acc_rst;
    end
  end

  `TCST_ASSERT_NEXT(a_load_rewinds_scan, clk, rst, cmd.load, cnt == '0)
  `TCST_ASSERT_NEXT(a_scan_advances, clk, rst, cmd.step && !status.scan_last,
                    cnt == $past(cnt) + tcst_pkg::SLOT_W'(1))
  `TCST_ASSERT_ALWAYS(a_scan_in_table, clk, rst, 32'(cnt) < tcst_pkg::NUM_SLOTS)

endmodule

// ===== sv/touch_contact_slot_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Touch contact slot tracker
// Keeps a table of touch contact slots updated by down, up, move, frame tick,
// clear and slot write events and read by query events, one result word per event word.
// ----------------------------------------------------------------------------
// From acceptance to the next acceptance, each event word is captured, then
// the controller walks the slot table and read-modify-writes each visited
// slot, and then the result is moved into the output register. A new event
// word can be accepted while the previous result is still waiting on
// out_stall; it only holds before publishing until the output register is
// free. Screen width and height reset to 480 and 320 and are written
// through the configuration port, which is always ready.

module touch_contact_slot_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tcst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcst_pkg::DIM_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           action,
  input  logic signed [tcst_pkg::COORD_W-1:0]  x_pos,
  input  logic signed [tcst_pkg::COORD_W-1:0]  y_pos,
  input  logic [tcst_pkg::ID_W-1:0]            contact_id,
  input  logic [tcst_pkg::IDX_W-1:0]           slot_index,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_left,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_top,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_right,
  input  logic signed [tcst_pkg::COORD_W-1:0]  rect_bottom,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 slot_hit,
  output logic                                 any_down,
  output logic                                 any_up,
  output logic                                 down_in_rect,
  output logic                                 up_in_rect,
  output logic                                 point_in_rect,
  output logic signed [tcst_pkg::COORD_W-1:0]  read_x,
  output logic signed [tcst_pkg::COORD_W-1:0]  read_y,
  output logic signed [tcst_pkg::OWNER_W-1:0]  read_id,
  output logic [1:0]                           read_status
);

  tcst_pkg::dp_cmd_t    cmd;
  tcst_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  tcst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcst_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .contact_id    (contact_id),
    .slot_index    (slot_index),
    .rect_left     (rect_left),
    .rect_top      (rect_top),
    .rect_right    (rect_right),
    .rect_bottom   (rect_bottom),
    .slot_hit      (slot_hit),
    .any_down      (any_down),
    .any_up        (any_up),
    .down_in_rect  (down_in_rect),
    .up_in_rect    (up_in_rect),
    .point_in_rect (point_in_rect),
    .read_x        (read_x),
    .read_y        (read_y),
    .read_id       (read_id),
    .read_status   (read_status)
  );

endmodule
